// File: rtl/segment_rect_nearest_hit_macros.svh
// ---------------------------------------------------------------------------
// segment_rect_nearest_hit assertion macros
// concurrent checks sampled on clk_i, off while rst_ni is low
// ---------------------------------------------------------------------------
`ifndef SEGMENT_RECT_NEAREST_HIT_MACROS_SVH
`define SEGMENT_RECT_NEAREST_HIT_MACROS_SVH

// same-cycle implication
`define SRNH_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("srnh check failed");

// next-cycle implication
`define SRNH_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("srnh check failed");

`endif

// File: rtl/srnh_pkg.sv
// ---------------------------------------------------------------------------
// srnh_pkg
// shared widths, side codes and pipeline records for the nearest hit block
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package srnh_pkg;

  localparam int NUM_SIDES  = 4;
  localparam int COORD_W    = 32;
  localparam int DIM_W      = 31;
  localparam int EXT_W      = 34;
  localparam int QUO_W      = 32;
  localparam int PROD_W     = 2 * QUO_W;
  localparam int DIST_W     = 2 * QUO_W;
  localparam int DIV_STEP   = 2;
  localparam int DIV_STAGES = QUO_W / DIV_STEP;
  localparam int SIDE_W     = 2;

  // output coordinate clamp bounds, held at the wide width
  localparam logic signed [EXT_W-1:0] SAT_MAX = EXT_W'(32'sh7fffffff);
  localparam logic signed [EXT_W-1:0] SAT_MIN = EXT_W'(32'sh80000000);

  typedef enum logic [SIDE_W-1:0] {
    SIDE_LEFT   = 2'd0,
    SIDE_RIGHT  = 2'd1,
    SIDE_TOP    = 2'd2,
    SIDE_BOTTOM = 2'd3
  } side_e;

  // per-side record carried alongside the divider
  typedef struct packed {
    logic                       ok;
    logic                       neg;
    logic [QUO_W-1:0]           moff;
    logic signed [COORD_W-1:0]  sb;
    logic signed [EXT_W-1:0]    lo;
    logic signed [EXT_W-1:0]    hi;
    logic signed [EXT_W-1:0]    c;
  } side_sb_t;

  // one candidate hit
  typedef struct packed {
    logic                       ok;
    logic [DIST_W-1:0]          dsq;
    logic signed [EXT_W-1:0]    x;
    logic signed [EXT_W-1:0]    y;
    side_e                      side;
    logic [NUM_SIDES-1:0]       mask;
  } cand_t;

endpackage

// File: rtl/srnh_div.sv
// ---------------------------------------------------------------------------
// srnh_div
// pipelined unsigned restoring divider, two quotient bits per stage
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module srnh_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic [srnh_pkg::PROD_W-1:0]   num_i,
  input  logic [srnh_pkg::QUO_W-1:0]    den_i,
  input  srnh_pkg::side_sb_t            sb_i,
  output logic                          valid_o,
  output logic [srnh_pkg::QUO_W-1:0]    quo_o,
  output srnh_pkg::side_sb_t            sb_o
);
  import srnh_pkg::*;

  logic                 v_q   [DIV_STAGES];
  logic [QUO_W-1:0]     rem_q [DIV_STAGES];
  logic [QUO_W-1:0]     low_q [DIV_STAGES];
  logic [QUO_W-1:0]     quo_q [DIV_STAGES];
  logic [QUO_W-1:0]     den_q [DIV_STAGES];
  side_sb_t             sb_q  [DIV_STAGES];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    logic             v_in;
    logic [QUO_W-1:0] rem_in, low_in, quo_in, den_in;
    side_sb_t         sb_in;
    logic [QUO_W-1:0] rem_d, low_d, quo_d;

    if (k == 0) begin : g_first
      // high half is below the divisor whenever the item can hit
      assign v_in   = valid_i;
      assign rem_in = num_i[PROD_W-1:QUO_W];
      assign low_in = num_i[QUO_W-1:0];
      assign quo_in = '0;
      assign den_in = den_i;
      assign sb_in  = sb_i;
    end else begin : g_next
      assign v_in   = v_q[k-1];
      assign rem_in = rem_q[k-1];
      assign low_in = low_q[k-1];
      assign quo_in = quo_q[k-1];
      assign den_in = den_q[k-1];
      assign sb_in  = sb_q[k-1];
    end

    always_comb begin
      logic [QUO_W:0] t;
      rem_d = rem_in;
      low_d = low_in;
      quo_d = quo_in;
      for (int j = 0; j < DIV_STEP; j++) begin
        t     = {rem_d, low_d[QUO_W-1]};
        low_d = {low_d[QUO_W-2:0], 1'b0};
        if (t >= {1'b0, den_in}) begin
          rem_d = QUO_W'(t - {1'b0, den_in});
          quo_d = {quo_d[QUO_W-2:0], 1'b1};
        end else begin
          rem_d = t[QUO_W-1:0];
          quo_d = {quo_d[QUO_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= rem_d;
        low_q[k] <= low_d;
        quo_q[k] <= quo_d;
        den_q[k] <= den_in;
        sb_q[k]  <= sb_in;
      end
    end
  end

  assign valid_o = v_q[DIV_STAGES-1];
  assign quo_o   = quo_q[DIV_STAGES-1];
  assign sb_o    = sb_q[DIV_STAGES-1];

endmodule

// File: rtl/srnh_side.sv
// ---------------------------------------------------------------------------
// srnh_side
// one rectangle side: range test, scaled crossing, extent test, distance
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module srnh_side (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                valid_i,
  input  logic signed [srnh_pkg::EXT_W-1:0]   c_i,
  input  logic signed [srnh_pkg::COORD_W-1:0] sa_i,
  input  logic signed [srnh_pkg::COORD_W-1:0] da_i,
  input  logic signed [srnh_pkg::COORD_W-1:0] sb_i,
  input  logic signed [srnh_pkg::COORD_W-1:0] db_i,
  input  logic signed [srnh_pkg::EXT_W-1:0]   lo_i,
  input  logic signed [srnh_pkg::EXT_W-1:0]   hi_i,
  input  logic                                ext_ok_i,
  output logic                                valid_o,
  output logic                                ok_o,
  output logic [srnh_pkg::DIST_W-1:0]         dist_o,
  output logic signed [srnh_pkg::EXT_W-1:0]   c_o,
  output logic signed [srnh_pkg::EXT_W-1:0]   b_o
);
  import srnh_pkg::*;

  // stage 1: offset to the side line
  logic                       v1_q;
  logic signed [EXT_W-1:0]    off1_q, c1_q, lo1_q, hi1_q;
  logic signed [COORD_W-1:0]  da1_q, db1_q, sb1_q;
  logic                       ext1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      off1_q <= c_i - EXT_W'(sa_i);
      c1_q   <= c_i;
      lo1_q  <= lo_i;
      hi1_q  <= hi_i;
      da1_q  <= da_i;
      db1_q  <= db_i;
      sb1_q  <= sb_i;
      ext1_q <= ext_ok_i;
    end
  end

  // stage 2: parameter range test and magnitudes
  logic signed [EXT_W-1:0]  da_x, off_abs;
  logic signed [COORD_W:0]  da_w, db_w, da_abs, db_abs;
  logic                     in_rng;
  side_sb_t                 sb2_d;

  always_comb begin
    da_x    = EXT_W'(da1_q);
    in_rng  = da1_q[COORD_W-1] ? (off1_q <= 0 && off1_q >= da_x)
                               : (off1_q >= 0 && off1_q <= da_x);
    off_abs = off1_q[EXT_W-1] ? -off1_q : off1_q;
    da_w    = (COORD_W+1)'(da1_q);
    db_w    = (COORD_W+1)'(db1_q);
    da_abs  = da_w[COORD_W] ? -da_w : da_w;
    db_abs  = db_w[COORD_W] ? -db_w : db_w;
    sb2_d.ok   = (da1_q != 0) && ext1_q && in_rng;
    sb2_d.neg  = off1_q[EXT_W-1] ^ db1_q[COORD_W-1] ^ da1_q[COORD_W-1];
    sb2_d.moff = off_abs[QUO_W-1:0];
    sb2_d.sb   = sb1_q;
    sb2_d.lo   = lo1_q;
    sb2_d.hi   = hi1_q;
    sb2_d.c    = c1_q;
  end

  logic             v2_q;
  side_sb_t         sb2_q;
  logic [QUO_W-1:0] mda2_q, mdb2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en_i) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sb2_q  <= sb2_d;
      mda2_q <= da_abs[QUO_W-1:0];
      mdb2_q <= db_abs[QUO_W-1:0];
    end
  end

  // stage 3: numerator magnitude
  logic              v3_q;
  side_sb_t          sb3_q;
  logic [QUO_W-1:0]  den3_q;
  logic [PROD_W-1:0] prod3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en_i) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sb3_q   <= sb2_q;
      den3_q  <= mda2_q;
      prod3_q <= PROD_W'(sb2_q.moff) * PROD_W'(mdb2_q);
    end
  end

  logic             vd;
  logic [QUO_W-1:0] quo;
  side_sb_t         sbd;

  srnh_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en_i),
    .valid_i (v3_q),
    .num_i   (prod3_q),
    .den_i   (den3_q),
    .sb_i    (sb3_q),
    .valid_o (vd),
    .quo_o   (quo),
    .sb_o    (sbd)
  );

  // stage 4: signed crossing, extent test, squares
  logic [QUO_W:0]          q_u;
  logic signed [QUO_W:0]   q_s;
  logic signed [EXT_W-1:0] b_d;
  logic                    inr;

  always_comb begin
    q_u = {1'b0, quo};
    q_s = sbd.neg ? -q_u : q_u;
    b_d = EXT_W'(sbd.sb) + EXT_W'(q_s);
    inr = (b_d >= sbd.lo) && (b_d <= sbd.hi);
  end

  logic                    v4_q, ok4_q;
  logic signed [EXT_W-1:0] c4_q, b4_q;
  logic [DIST_W-1:0]       sqo4_q, sqq4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (en_i) begin
      v4_q <= vd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ok4_q  <= sbd.ok && inr;
      c4_q   <= sbd.c;
      b4_q   <= b_d;
      sqo4_q <= DIST_W'(sbd.moff) * DIST_W'(sbd.moff);
      sqq4_q <= DIST_W'(quo) * DIST_W'(quo);
    end
  end

  // stage 5: squared distance
  logic                    v5_q, ok5_q;
  logic [DIST_W-1:0]       dist5_q;
  logic signed [EXT_W-1:0] c5_q, b5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else if (en_i) begin
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ok5_q   <= ok4_q;
      dist5_q <= sqo4_q + sqq4_q;
      c5_q    <= c4_q;
      b5_q    <= b4_q;
    end
  end

  assign valid_o = v5_q;
  assign ok_o    = ok5_q;
  assign dist_o  = dist5_q;
  assign c_o     = c5_q;
  assign b_o     = b5_q;

endmodule

// File: rtl/srnh_pick.sv
// ---------------------------------------------------------------------------
// srnh_pick
// registered two-level nearest selection and saturating output register
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module srnh_pick (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 en_i,
  input  logic                                 valid_i,
  input  srnh_pkg::cand_t                      cand_i [srnh_pkg::NUM_SIDES],
  output logic                                 valid_o,
  output logic                                 hit_o,
  output logic signed [srnh_pkg::COORD_W-1:0]  hit_x_o,
  output logic signed [srnh_pkg::COORD_W-1:0]  hit_y_o,
  output logic [srnh_pkg::SIDE_W-1:0]          hit_side_o,
  output logic [srnh_pkg::NUM_SIDES-1:0]       side_mask_o
);
  import srnh_pkg::*;

  // b is the later side: it wins ties and merges the mask
  function automatic cand_t nearer(cand_t a, cand_t b);
    cand_t r;
    r = a;
    if (b.ok) begin
      if (!a.ok || b.dsq < a.dsq) begin
        r = b;
      end else if (b.dsq == a.dsq) begin
        r      = b;
        r.mask = a.mask | b.mask;
      end
    end
    return r;
  endfunction

  function automatic logic signed [COORD_W-1:0] sat(logic signed [EXT_W-1:0] v);
    logic signed [COORD_W-1:0] r;
    if (v > SAT_MAX) begin
      r = SAT_MAX[COORD_W-1:0];
    end else if (v < SAT_MIN) begin
      r = SAT_MIN[COORD_W-1:0];
    end else begin
      r = v[COORD_W-1:0];
    end
    return r;
  endfunction

  logic  v1_q, v2_q, v3_q;
  cand_t lo_pair_q, hi_pair_q, best_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lo_pair_q   <= nearer(cand_i[0], cand_i[1]);
      hi_pair_q   <= nearer(cand_i[2], cand_i[3]);
      best_q      <= nearer(lo_pair_q, hi_pair_q);
      hit_o       <= best_q.ok;
      hit_x_o     <= best_q.ok ? sat(best_q.x) : '0;
      hit_y_o     <= best_q.ok ? sat(best_q.y) : '0;
      hit_side_o  <= best_q.ok ? best_q.side : SIDE_LEFT;
      side_mask_o <= best_q.ok ? best_q.mask : '0;
    end
  end

  assign valid_o = v3_q;

endmodule

// File: rtl/segment_rect_nearest_hit.sv
// ---------------------------------------------------------------------------
// segment_rect_nearest_hit
// nearest crossing of a fixed-point segment with an axis-aligned rectangle
// ---------------------------------------------------------------------------
// Takes one segment/rectangle query per cycle while in_ready_o is high and
// returns one result per query, in order.
// The whole pipeline moves as one: while a finished result waits on
// out_ready_i every stage holds and in_ready_o is low, otherwise a new item is
// taken each cycle. The path runs through the per-side 32-bit quotient, produced
// by a 16-stage divider at two bits per stage, plus the edge, product, square
// and nearest-selection stages around it.
`timescale 1ns / 1ps

module segment_rect_nearest_hit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [srnh_pkg::COORD_W-1:0]  seg_x_i,
  input  logic signed [srnh_pkg::COORD_W-1:0]  seg_y_i,
  input  logic signed [srnh_pkg::COORD_W-1:0]  seg_dx_i,
  input  logic signed [srnh_pkg::COORD_W-1:0]  seg_dy_i,
  input  logic signed [srnh_pkg::COORD_W-1:0]  rect_cx_i,
  input  logic signed [srnh_pkg::COORD_W-1:0]  rect_cy_i,
  input  logic [srnh_pkg::DIM_W-1:0]           rect_w_i,
  input  logic [srnh_pkg::DIM_W-1:0]           rect_h_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic                                 hit_o,
  output logic signed [srnh_pkg::COORD_W-1:0]  hit_x_o,
  output logic signed [srnh_pkg::COORD_W-1:0]  hit_y_o,
  output logic [srnh_pkg::SIDE_W-1:0]          hit_side_o,
  output logic [srnh_pkg::NUM_SIDES-1:0]       side_mask_o
);
  import srnh_pkg::*;
  `include "segment_rect_nearest_hit_macros.svh"

  logic en;
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  // stage 0: side lines
  logic signed [EXT_W-1:0]   hw, hh;
  logic                      v0_q;
  logic signed [COORD_W-1:0] sx_q, sy_q, dx_q, dy_q;
  logic signed [EXT_W-1:0]   line_l_q, line_r_q, line_t_q, line_b_q;
  logic                      w_ok_q, h_ok_q;

  assign hw = EXT_W'(rect_w_i[DIM_W-1:1]);
  assign hh = EXT_W'(rect_h_i[DIM_W-1:1]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en) begin
      v0_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sx_q     <= seg_x_i;
      sy_q     <= seg_y_i;
      dx_q     <= seg_dx_i;
      dy_q     <= seg_dy_i;
      line_l_q <= EXT_W'(rect_cx_i) - hw;
      line_r_q <= EXT_W'(rect_cx_i) + hw;
      line_t_q <= EXT_W'(rect_cy_i) + hh;
      line_b_q <= EXT_W'(rect_cy_i) - hh;
      w_ok_q   <= rect_w_i != '0;
      h_ok_q   <= rect_h_i != '0;
    end
  end

  logic [NUM_SIDES-1:0]    side_v, side_ok;
  logic [DIST_W-1:0]       side_dist [NUM_SIDES];
  logic signed [EXT_W-1:0] side_c [NUM_SIDES];
  logic signed [EXT_W-1:0] side_b [NUM_SIDES];

  srnh_side u_left (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (en), .valid_i (v0_q),
    .c_i (line_l_q), .sa_i (sx_q), .da_i (dx_q), .sb_i (sy_q), .db_i (dy_q),
    .lo_i (line_b_q), .hi_i (line_t_q), .ext_ok_i (h_ok_q),
    .valid_o (side_v[0]), .ok_o (side_ok[0]), .dist_o (side_dist[0]),
    .c_o (side_c[0]), .b_o (side_b[0])
  );

  srnh_side u_right (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (en), .valid_i (v0_q),
    .c_i (line_r_q), .sa_i (sx_q), .da_i (dx_q), .sb_i (sy_q), .db_i (dy_q),
    .lo_i (line_b_q), .hi_i (line_t_q), .ext_ok_i (h_ok_q),
    .valid_o (side_v[1]), .ok_o (side_ok[1]), .dist_o (side_dist[1]),
    .c_o (side_c[1]), .b_o (side_b[1])
  );

  srnh_side u_top (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (en), .valid_i (v0_q),
    .c_i (line_t_q), .sa_i (sy_q), .da_i (dy_q), .sb_i (sx_q), .db_i (dx_q),
    .lo_i (line_l_q), .hi_i (line_r_q), .ext_ok_i (w_ok_q),
    .valid_o (side_v[2]), .ok_o (side_ok[2]), .dist_o (side_dist[2]),
    .c_o (side_c[2]), .b_o (side_b[2])
  );

  srnh_side u_bottom (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (en), .valid_i (v0_q),
    .c_i (line_b_q), .sa_i (sy_q), .da_i (dy_q), .sb_i (sx_q), .db_i (dx_q),
    .lo_i (line_l_q), .hi_i (line_r_q), .ext_ok_i (w_ok_q),
    .valid_o (side_v[3]), .ok_o (side_ok[3]), .dist_o (side_dist[3]),
    .c_o (side_c[3]), .b_o (side_b[3])
  );

  // vertical sides cross at x = line, horizontal ones at y = line
  cand_t cand [NUM_SIDES];

  always_comb begin
    for (int i = 0; i < NUM_SIDES; i++) begin
      cand[i].ok   = side_ok[i];
      cand[i].dsq  = side_dist[i];
      cand[i].mask = NUM_SIDES'(1) << i;
    end
    cand[0].x = side_c[0];  cand[0].y = side_b[0];  cand[0].side = SIDE_LEFT;
    cand[1].x = side_c[1];  cand[1].y = side_b[1];  cand[1].side = SIDE_RIGHT;
    cand[2].x = side_b[2];  cand[2].y = side_c[2];  cand[2].side = SIDE_TOP;
    cand[3].x = side_b[3];  cand[3].y = side_c[3];  cand[3].side = SIDE_BOTTOM;
  end

  srnh_pick u_pick (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .valid_i     (side_v[0]),
    .cand_i      (cand),
    .valid_o     (out_valid_o),
    .hit_o       (hit_o),
    .hit_x_o     (hit_x_o),
    .hit_y_o     (hit_y_o),
    .hit_side_o  (hit_side_o),
    .side_mask_o (side_mask_o)
  );

  `SRNH_ASSERT_NOW(a_side_valid_agree, 1'b1, side_v == {NUM_SIDES{side_v[0]}})
  `SRNH_ASSERT_NOW(a_miss_is_zero, out_valid_o && !hit_o,
                   side_mask_o == '0 && hit_x_o == '0 && hit_y_o == '0 && hit_side_o == '0)
  `SRNH_ASSERT_NOW(a_hit_side_in_mask, out_valid_o && hit_o, side_mask_o[hit_side_o])

endmodule
